FILE: hw/rtl/wfk_pkg.sv
package wfk_pkg;

   // cordic configuration
   localparam int CORDIC_STEPS = 16;
   localparam int ATAN_ENTRIES = 24;
   localparam int NSTEP = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
   localparam int CW = 34;          // x/y datapath width, q30 plus headroom
   localparam int ZW = 34;          // angle width, units of pi/2^29
   localparam logic signed [CW-1:0] INV_GAIN_Q30 = 34'sd652032874;
   localparam logic signed [17:0] ROT_MAX = 18'sd65536;
   localparam logic signed [17:0] ROT_MIN = -18'sd65536;
   localparam logic signed [23:0] POS_MAX = 24'sd8388607;
   localparam logic signed [23:0] POS_MIN = -24'sd8388608;

   // register indexes
   localparam logic [2:0] REG_MOUNT_X = 3'd0;
   localparam logic [2:0] REG_MOUNT_Y = 3'd1;
   localparam logic [2:0] REG_MOUNT_Z = 3'd2;
   localparam logic [2:0] REG_WRIST = 3'd3;
   localparam logic [2:0] REG_TIP = 3'd4;

   // atan(2^-i) in units of pi/2^29
   function automatic logic signed [ZW-1:0] atan_val(input int i);
      logic signed [ZW-1:0] v;
      begin
         v = '0;
         case (i)
            0: v = 34'sd134217728;  1: v = 34'sd79233351;  2: v = 34'sd41864727;
            3: v = 34'sd21251189;   4: v = 34'sd10666833;  5: v = 34'sd5338616;
            6: v = 34'sd2669960;    7: v = 34'sd1335061;   8: v = 34'sd667541;
            9: v = 34'sd333772;    10: v = 34'sd166886;   11: v = 34'sd83443;
            12: v = 34'sd41722;    13: v = 34'sd20861;    14: v = 34'sd10430;
            15: v = 34'sd5215;     16: v = 34'sd2608;     17: v = 34'sd1304;
            18: v = 34'sd652;      19: v = 34'sd326;      20: v = 34'sd163;
            21: v = 34'sd81;       22: v = 34'sd41;       default: v = 34'sd20;
         endcase
         return v;
      end
   endfunction

   // clamp a wide value into the rotation range
   function automatic logic signed [17:0] clamp_rot(input logic signed [47:0] v);
      begin
         if (v > 48'sd65536) return ROT_MAX;
         else if (v < -48'sd65536) return ROT_MIN;
         else return v[17:0];
      end
   endfunction

   // per-angle cordic lane state
   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [ZW-1:0] z;
      logic neg;
   } lane_type;

   typedef struct packed {
      logic signed [17:0] c1;
      logic signed [17:0] s1;
      logic signed [17:0] c2;
      logic signed [17:0] s2;
   } trig_type;

endpackage

FILE: hw/rtl/wfk_cordic_stage.sv
module wfk_cordic_stage (
   input  logic                clock,
   input  logic                enable,
   input  logic [4:0]          step,
   input  wfk_pkg::lane_type   lane_a_in,
   input  wfk_pkg::lane_type   lane_b_in,
   output wfk_pkg::lane_type   lane_a_ff,
   output wfk_pkg::lane_type   lane_b_ff
);

   wfk_pkg::lane_type lane_a_in2, lane_b_in2;

   // one micro-rotation of a single lane, used for both angles
   function automatic wfk_pkg::lane_type rot(input wfk_pkg::lane_type l, input logic [4:0] i);
      wfk_pkg::lane_type r;
      logic signed [wfk_pkg::CW-1:0] xs, ys;
      begin
         r = l;
         xs = l.x >>> i;
         ys = l.y >>> i;
         if (!l.z[wfk_pkg::ZW-1]) begin
            r.x = l.x - ys;
            r.y = l.y + xs;
            r.z = l.z - wfk_pkg::atan_val(int'(i));
         end else begin
            r.x = l.x + ys;
            r.y = l.y - xs;
            r.z = l.z + wfk_pkg::atan_val(int'(i));
         end
         return r;
      end
   endfunction

   assign lane_a_in2 = rot(lane_a_in, step);
   assign lane_b_in2 = rot(lane_b_in, step);

   always_ff @(posedge clock) begin
      if (enable) begin
         lane_a_ff <= lane_a_in2;
         lane_b_ff <= lane_b_in2;
      end
   end

endmodule

FILE: hw/rtl/wfk_pose_calc.sv
module wfk_pose_calc (
   input  logic                      clock,
   input  logic                      enable,
   input  wfk_pkg::trig_type         trig,
   input  logic signed [21:0]        mount_x,
   input  logic signed [21:0]        mount_y,
   input  logic signed [21:0]        mount_z,
   input  logic [19:0]               wrist_length,
   input  logic [19:0]               tip_length,
   output logic [233:0]              pose_ff
);

   // stage p1: rotation products, wrist terms and the y tip term
   wfk_pkg::trig_type trig_ff;
   logic signed [17:0] r00_ff, r01_ff, r06_ff, r07_ff;
   logic signed [23:0] wx_ff, wz_ff, ty_ff;
   logic signed [17:0] r00_in, r01_in, r06_in, r07_in;
   logic signed [23:0] wx_in, wz_in, ty_in;
   logic signed [23:0] tx_ff, tz_ff, tx_in, tz_in;
   logic signed [17:0] q00_ff, q01_ff, q06_ff, q07_ff;
   logic signed [23:0] px_in, py_in, pz_in;
   wfk_pkg::trig_type trig2_ff;
   logic signed [23:0] wx2_ff, wz2_ff, ty2_ff;

   function automatic logic signed [17:0] mulq(input logic signed [17:0] a,
                                               input logic signed [17:0] b);
      logic signed [47:0] p;
      begin
         p = 48'(a) * 48'(b) + 48'sd32768;
         return wfk_pkg::clamp_rot(p >>> 16);
      end
   endfunction

   function automatic logic signed [23:0] lterm(input logic [19:0] len,
                                                input logic signed [17:0] q);
      logic signed [47:0] p;
      begin
         p = $signed({28'd0, len}) * 48'(q) + 48'sd32768;
         p = p >>> 16;
         return p[23:0];
      end
   endfunction

   function automatic logic signed [23:0] sat(input logic signed [25:0] v);
      begin
         if (v > 26'sd8388607) return wfk_pkg::POS_MAX;
         else if (v < -26'sd8388608) return wfk_pkg::POS_MIN;
         else return v[23:0];
      end
   endfunction

   assign r00_in = mulq(trig.c1, trig.c2);
   assign r01_in = mulq(trig.c1, trig.s2);
   assign r06_in = mulq(trig.s1, trig.c2);
   assign r07_in = mulq(trig.s1, trig.s2);
   assign wx_in = lterm(wrist_length, trig.c1);
   assign wz_in = lterm(wrist_length, trig.s1);
   assign ty_in = lterm(tip_length, trig.s2);

   always_ff @(posedge clock) begin
      if (enable) begin
         trig_ff <= trig;
         r00_ff <= r00_in; r01_ff <= r01_in; r06_ff <= r06_in; r07_ff <= r07_in;
         wx_ff <= wx_in; wz_ff <= wz_in; ty_ff <= ty_in;
      end
   end

   // stage p2: tip terms from the rotated column
   assign tx_in = lterm(tip_length, r00_ff);
   assign tz_in = lterm(tip_length, r06_ff);

   always_ff @(posedge clock) begin
      if (enable) begin
         trig2_ff <= trig_ff;
         q00_ff <= r00_ff; q01_ff <= r01_ff; q06_ff <= r06_ff; q07_ff <= r07_ff;
         wx2_ff <= wx_ff; wz2_ff <= wz_ff; ty2_ff <= ty_ff;
         tx_ff <= tx_in; tz_ff <= tz_in;
      end
   end

   // stage p3: sums, saturation and packing
   assign px_in = sat(26'(mount_x) + 26'(wx2_ff) + 26'(tx_ff));
   assign py_in = sat(26'(mount_y) + 26'(ty2_ff));
   assign pz_in = sat(26'(mount_z) + 26'(wz2_ff) + 26'(tz_ff));

   always_ff @(posedge clock) begin
      if (enable) begin
         pose_ff <= {pz_in, py_in, px_in,
                     trig2_ff.c1, -q07_ff, q06_ff,
                     18'sd0, trig2_ff.c2, trig2_ff.s2,
                     -trig2_ff.s1, -q01_ff, q00_ff};
      end
   end

endmodule

FILE: hw/rtl/wrist_forward_kinematics_core.sv
// Two-joint wrist forward kinematics. One angle pair per beat; a new beat is
// accepted every cycle while the output register is empty or rsp_tready is high.
// The pipeline has one fold stage, one stage per CORDIC micro-rotation (both
// angles in parallel), one rounding stage and three pose stages (products, tip
// terms, sums with saturation). The whole pipeline advances only when its output
// register is empty or being drained. Registers must be written over the csr_
// port while the block is idle; the block does not enforce this. The lengths
// feed the product and tip term stages, the mount offsets the last pose stage.
module wrist_forward_kinematics_core (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [31:0]   req_tdata,   // first_angle[15:0], second_angle[31:16]
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // rot_00..rot_22 at [161:0] (18 bits each, row order), pos_x [185:162],
   // pos_y [209:186], pos_z [233:210], zero fill to 239
   output logic [239:0]  rsp_tdata,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [2:0]    csr_index,
   input  logic [31:0]   csr_data
);

   localparam int DEPTH = wfk_pkg::NSTEP + 5;

   logic signed [21:0] mount_x_ff, mount_y_ff, mount_z_ff;
   logic [19:0] wrist_ff, tip_ff;
   logic [DEPTH-1:0] valid_ff, valid_in;
   logic advance;
   wfk_pkg::lane_type lane_a [0:wfk_pkg::NSTEP];
   wfk_pkg::lane_type lane_b [0:wfk_pkg::NSTEP];
   wfk_pkg::lane_type fold_a_in, fold_b_in;
   wfk_pkg::trig_type trig_ff, trig_in;
   logic [233:0] pose;

   assign advance = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;
   assign csr_ready = 1'b1;
   assign rsp_tvalid = valid_ff[DEPTH-1];
   assign rsp_tdata = {6'd0, pose};

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mount_x_ff <= 22'sd459276;
         mount_y_ff <= 22'sd0;
         mount_z_ff <= 22'sd65012;
         wrist_ff <= 20'd9227;
         tip_ff <= 20'd17826;
      end else if (csr_valid) begin
         unique case (csr_index)
            wfk_pkg::REG_MOUNT_X: mount_x_ff <= csr_data[21:0];
            wfk_pkg::REG_MOUNT_Y: mount_y_ff <= csr_data[21:0];
            wfk_pkg::REG_MOUNT_Z: mount_z_ff <= csr_data[21:0];
            wfk_pkg::REG_WRIST:   wrist_ff <= csr_data[19:0];
            wfk_pkg::REG_TIP:     tip_ff <= csr_data[19:0];
            default: ;
         endcase
      end
   end

   // valid bits travel with the data
   assign valid_in = {valid_ff[DEPTH-2:0], req_tvalid};
   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else if (advance) valid_ff <= valid_in;
   end

   // fold angle into [-pi/2, pi/2]
   function automatic wfk_pkg::lane_type fold(input logic signed [15:0] a);
      wfk_pkg::lane_type l;
      logic signed [16:0] b;
      begin
         b = 17'(a);
         l.neg = 1'b0;
         if (a > 16'sd16384) begin b = b - 17'sd32768; l.neg = 1'b1; end
         else if (a < -16'sd16384) begin b = b + 17'sd32768; l.neg = 1'b1; end
         l.x = wfk_pkg::INV_GAIN_Q30;
         l.y = '0;
         l.z = wfk_pkg::ZW'(b) <<< 14;
         return l;
      end
   endfunction

   assign fold_a_in = fold(req_tdata[15:0]);
   assign fold_b_in = fold(req_tdata[31:16]);

   always_ff @(posedge clock) begin
      if (advance) begin
         lane_a[0] <= fold_a_in;
         lane_b[0] <= fold_b_in;
      end
   end

   // cordic stages
   for (genvar g = 0; g < wfk_pkg::NSTEP; g++) begin : g_step
      wfk_cordic_stage u_stage (
         .clock(clock), .enable(advance), .step(5'(g)),
         .lane_a_in(lane_a[g]), .lane_b_in(lane_b[g]),
         .lane_a_ff(lane_a[g+1]), .lane_b_ff(lane_b[g+1])
      );
   end

   // round to q16 and apply fold sign
   function automatic logic signed [17:0] rnd(input logic signed [wfk_pkg::CW-1:0] v,
                                              input logic neg);
      logic signed [47:0] w;
      logic signed [17:0] r;
      begin
         w = (48'(v) + 48'sd8192) >>> 14;
         r = wfk_pkg::clamp_rot(w);
         return neg ? -r : r;
      end
   endfunction

   assign trig_in.c1 = rnd(lane_a[wfk_pkg::NSTEP].x, lane_a[wfk_pkg::NSTEP].neg);
   assign trig_in.s1 = rnd(lane_a[wfk_pkg::NSTEP].y, lane_a[wfk_pkg::NSTEP].neg);
   assign trig_in.c2 = rnd(lane_b[wfk_pkg::NSTEP].x, lane_b[wfk_pkg::NSTEP].neg);
   assign trig_in.s2 = rnd(lane_b[wfk_pkg::NSTEP].y, lane_b[wfk_pkg::NSTEP].neg);

   always_ff @(posedge clock) begin
      if (advance) trig_ff <= trig_in;
   end

   wfk_pose_calc u_pose (
      .clock(clock), .enable(advance), .trig(trig_ff),
      .mount_x(mount_x_ff), .mount_y(mount_y_ff), .mount_z(mount_z_ff),
      .wrist_length(wrist_ff), .tip_length(tip_ff), .pose_ff(pose)
   );

   // a stalled result holds its payload
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed under stall");
   // stalled pipeline does not shift
   a_freeze: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(valid_ff))
      else $error("pipeline moved while stalled");
   // rotation entry r12 is always zero
   a_r12: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[107:90] == 18'd0)
      else $error("rot_12 nonzero");

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   localparam int PIPE_DEPTH = wfk_pkg::NSTEP + 5;
   localparam int CYCLE_LIMIT = 400000;
   localparam int N_RANDOM = 400;

   typedef struct {
      logic signed [15:0] a1;
      logic signed [15:0] a2;
      logic               has_pose;
      logic [239:0]       pose;
   } stim_row_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [31:0]   req_tdata = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [239:0]  rsp_tdata;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   logic [2:0]    csr_index = '0;
   logic [31:0]   csr_data = '0;

   // predictor copy of the registers
   longint mount_x_q, mount_y_q, mount_z_q, wrist_q, tip_q;

   logic [239:0]  pose_queue [$];
   int            errors = 0;
   int            cycle_count = 0;
   int            send_idle_pct = 0;
   int            recv_stall_pct = 0;

   wrist_forward_kinematics_core dut (.*);

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("wrist_forward_kinematics_core test failed");
         $finish;
      end
   end

   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint atan_angle(int i);
      longint tab [24] = '{134217728, 79233351, 41864727, 21251189, 10666833, 5338616,
                           2669960, 1335061, 667541, 333772, 166886, 83443,
                           41722, 20861, 10430, 5215, 2608, 1304,
                           652, 326, 163, 81, 41, 20};
      return tab[i];
   endfunction

   // cordic sine and cosine in q.16
   task automatic trig_q16(input longint ang, output longint c, output longint s);
      longint x, y, z, nx;
      x = 652032874;
      y = 0;
      c = 0;
      s = 0;
      if (ang > 16384) begin
         ang -= 32768;
         c = 1;
      end else if (ang < -16384) begin
         ang += 32768;
         c = 1;
      end
      s = c;
      z = ang * 16384;
      for (int i = 0; i < wfk_pkg::CORDIC_STEPS && i < 24; i++) begin
         if (z >= 0) begin
            nx = x - floor_shift(y, i);
            y = y + floor_shift(x, i);
            z -= atan_angle(i);
         end else begin
            nx = x + floor_shift(y, i);
            y = y - floor_shift(x, i);
            z += atan_angle(i);
         end
         x = nx;
      end
      x = clip(floor_shift(x + 8192, 14), -65536, 65536);
      y = clip(floor_shift(y + 8192, 14), -65536, 65536);
      if (s != 0) begin
         x = -x;
         y = -y;
      end
      c = x;
      s = y;
   endtask

   function automatic longint prod_q16(longint a, longint b);
      return clip(floor_shift(a * b + 32768, 16), -65536, 65536);
   endfunction

   function automatic longint len_q16(longint len, longint q);
      return floor_shift(len * q + 32768, 16);
   endfunction

   // expected pose for one angle pair
   task automatic predict_pose(input logic signed [15:0] a1, input logic signed [15:0] a2,
                               output logic [239:0] pose);
      longint c1, s1, c2, s2, px, py, pz;
      longint r [9];
      trig_q16(longint'(a1), c1, s1);
      trig_q16(longint'(a2), c2, s2);
      r[0] = prod_q16(c1, c2);
      r[1] = -prod_q16(c1, s2);
      r[2] = -s1;
      r[3] = s2;
      r[4] = c2;
      r[5] = 0;
      r[6] = prod_q16(s1, c2);
      r[7] = -prod_q16(s1, s2);
      r[8] = c1;
      px = mount_x_q + len_q16(wrist_q, c1) + len_q16(tip_q, r[0]);
      py = mount_y_q + len_q16(tip_q, s2);
      pz = mount_z_q + len_q16(wrist_q, s1) + len_q16(tip_q, r[6]);
      pose = '0;
      for (int k = 0; k < 9; k++)
         pose[k*18 +: 18] = r[k][17:0];
      pose[162 +: 24] = 24'(clip(px, -8388608, 8388607));
      pose[186 +: 24] = 24'(clip(py, -8388608, 8388607));
      pose[210 +: 24] = 24'(clip(pz, -8388608, 8388607));
   endtask

   // result checker and receiver stalls
   always @(posedge clock) begin
      logic [239:0] want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (pose_queue.size() == 0) begin
               $display("%0t: unexpected result beat %h", $time, rsp_tdata);
               errors++;
            end else begin
               want = pose_queue.pop_front();
               for (int k = 0; k < 9; k++)
                  if (want[k*18 +: 18] !== rsp_tdata[k*18 +: 18]) begin
                     $display("%0t: rot[%0d] expected %0d actual %0d", $time, k,
                              $signed(want[k*18 +: 18]), $signed(rsp_tdata[k*18 +: 18]));
                     errors++;
                  end
               for (int k = 0; k < 3; k++)
                  if (want[162 + k*24 +: 24] !== rsp_tdata[162 + k*24 +: 24]) begin
                     $display("%0t: pos[%0d] expected %0d actual %0d", $time, k,
                              $signed(want[162 + k*24 +: 24]),
                              $signed(rsp_tdata[162 + k*24 +: 24]));
                     errors++;
                  end
               if (want[239:234] !== rsp_tdata[239:234]) begin
                  $display("%0t: fill expected %h actual %h", $time, want[239:234],
                           rsp_tdata[239:234]);
                  errors++;
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // register write over the csr port; csr_valid goes low again after each beat
   task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         wfk_pkg::REG_MOUNT_X: mount_x_q = longint'($signed(val[21:0]));
         wfk_pkg::REG_MOUNT_Y: mount_y_q = longint'($signed(val[21:0]));
         wfk_pkg::REG_MOUNT_Z: mount_z_q = longint'($signed(val[21:0]));
         wfk_pkg::REG_WRIST:   wrist_q = longint'(val[19:0]);
         wfk_pkg::REG_TIP:     tip_q = longint'(val[19:0]);
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      while (pose_queue.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 4) @(posedge clock);
   endtask

   // send one angle pair, queue the expected pose
   task automatic send_pair(input logic signed [15:0] a1, input logic signed [15:0] a2,
                            input logic has_pose, input logic [239:0] typed);
      logic [239:0] pose;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      predict_pose(a1, a2, pose);
      if (has_pose && typed !== pose) begin
         $display("%0t: table row expected %h predictor %h", $time, typed, pose);
         errors++;
      end
      pose_queue.push_back(has_pose ? typed : pose);
      req_tvalid <= 1'b1;
      req_tdata <= {a2, a1};
      do @(posedge clock); while (!req_tready);
   endtask

   initial begin
      stim_row_type table_rows [$];
      logic signed [15:0] a1, a2;
      int phase_pct [4][2] = '{'{0, 0}, '{79, 0}, '{0, 79}, '{38, 38}};

      mount_x_q = 459276;
      mount_y_q = 0;
      mount_z_q = 65012;
      wrist_q = 9227;
      tip_q = 17826;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table: zero angles, quadrants, fold edges, minus pi, extremes
      table_rows.push_back('{16'sd0, 16'sd0, 1'b0, '0});
      table_rows.push_back('{16'sd16384, 16'sd0, 1'b0, '0});
      table_rows.push_back('{-16'sd16384, 16'sd0, 1'b0, '0});
      table_rows.push_back('{16'sd16385, 16'sd16384, 1'b0, '0});
      table_rows.push_back('{-16'sd16385, -16'sd16384, 1'b0, '0});
      table_rows.push_back('{-16'sd32768, 16'sd0, 1'b0, '0});
      table_rows.push_back('{16'sd0, -16'sd32768, 1'b0, '0});
      table_rows.push_back('{16'sd32767, 16'sd32767, 1'b0, '0});
      table_rows.push_back('{-16'sd32768, -16'sd32768, 1'b0, '0});
      table_rows.push_back('{16'sd8192, -16'sd8192, 1'b0, '0});
      table_rows.push_back('{16'sd1, -16'sd1, 1'b0, '0});
      table_rows.push_back('{16'sh5555, 16'shAAAA, 1'b0, '0});
      table_rows.push_back('{16'shAAAA, 16'sh5555, 1'b0, '0});
      foreach (table_rows[i])
         send_pair(table_rows[i].a1, table_rows[i].a2, table_rows[i].has_pose,
                   table_rows[i].pose);
      drain();

      // register extremes: all at maximum, then smallest offsets and wrist
      write_reg(wfk_pkg::REG_MOUNT_X, 32'h001F_FFFF);
      write_reg(wfk_pkg::REG_MOUNT_Y, 32'h001F_FFFF);
      write_reg(wfk_pkg::REG_MOUNT_Z, 32'h001F_FFFF);
      write_reg(wfk_pkg::REG_WRIST, 32'h000F_FFFF);
      write_reg(wfk_pkg::REG_TIP, 32'h000F_FFFF);
      send_pair(16'sd0, 16'sd0, 1'b0, '0);
      send_pair(16'sd0, 16'sd16384, 1'b0, '0);
      send_pair(-16'sd32768, -16'sd32768, 1'b0, '0);
      drain();
      write_reg(wfk_pkg::REG_MOUNT_X, 32'h0020_0000);
      write_reg(wfk_pkg::REG_MOUNT_Y, 32'h0020_0000);
      write_reg(wfk_pkg::REG_MOUNT_Z, 32'h0020_0000);
      write_reg(wfk_pkg::REG_WRIST, 32'h0000_0000);
      write_reg(wfk_pkg::REG_TIP, 32'h000F_FFFF);
      send_pair(-16'sd32768, 16'sd0, 1'b0, '0);
      send_pair(16'sd0, -16'sd16384, 1'b0, '0);
      send_pair(-16'sd16384, -16'sd32768, 1'b0, '0);
      drain();

      // random phases, each with fresh register settings
      for (int ph = 0; ph < 4; ph++) begin
         write_reg(wfk_pkg::REG_MOUNT_X, $urandom);
         write_reg(wfk_pkg::REG_MOUNT_Y, $urandom);
         write_reg(wfk_pkg::REG_MOUNT_Z, $urandom);
         write_reg(wfk_pkg::REG_WRIST, $urandom);
         write_reg(wfk_pkg::REG_TIP, $urandom);
         send_idle_pct = phase_pct[ph][0];
         recv_stall_pct = phase_pct[ph][1];
         for (int n = 0; n < N_RANDOM / 4; n++) begin
            a1 = 16'($urandom);
            a2 = 16'($urandom);
            if ($urandom_range(9) == 0) a1 = 16'sh8000 ^ 16'($urandom_range(1));
            send_pair(a1, a2, 1'b0, '0);
            // one pause until all results are out
            if (ph == 0 && n == 50) drain();
         end
         drain();
      end

      send_idle_pct = 0;
      recv_stall_pct = 0;
      drain();
      if (errors == 0)
         $display("wrist_forward_kinematics_core test passed");
      else
         $display("wrist_forward_kinematics_core test failed");
      $finish;
   end

endmodule
